// File: src/shared_counter_compare_timer_core_assert.svh
// Assertion macros used by the timer RTL execute unit.
`ifndef SHARED_COUNTER_COMPARE_TIMER_CORE_ASSERT_SVH
`define SHARED_COUNTER_COMPARE_TIMER_CORE_ASSERT_SVH

// Property that must hold in the cycle after the antecedent.
`define SCCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Property that must hold in the same cycle as the antecedent.
`define SCCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/scct_pkg.sv
// Package: widths, access codes and beat structs of the shared counter timer.
`default_nettype none
package scct_pkg;

   localparam int NUM_VPS = 8;
   localparam int SLOTS   = 8;
   localparam int DATA_W  = 32;
   localparam int VP_W    = 3;
   localparam int MODE_W  = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK      = 3'd0,
      MODE_WR_COUNT  = 3'd1,
      MODE_RD_COUNT  = 3'd2,
      MODE_WR_CMP    = 3'd3,
      MODE_RD_CMP    = 3'd4,
      MODE_START     = 3'd5,
      MODE_STOP      = 3'd6,
      MODE_RD_STOP   = 3'd7
   } mode_type;

   typedef struct packed {
      logic              go;
      mode_type          mode;
      logic [VP_W-1:0]   vp;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [SLOTS-1:0]  match_mask;
   } rsp_type;

endpackage
`default_nettype wire

// File: src/scct_exec.sv
// Execute unit: counter, compare bank, stop flag and result formation.
`default_nettype none
`include "shared_counter_compare_timer_core_assert.svh"
module scct_exec
   import scct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output rsp_type      rsp
);

   logic [DATA_W-1:0] count_ff, count_in;
   logic              stopped_ff, stopped_in;
   logic [DATA_W-1:0] cmp_ff [SLOTS];
   logic [DATA_W-1:0] next_count;
   logic              vp_ok;
   logic              cmp_we;

   assign next_count = count_ff + DATA_W'(1);
   assign vp_ok      = int'(cmd.vp) < NUM_VPS;
   assign cmp_we     = cmd.go && (cmd.mode == MODE_WR_CMP) && vp_ok;

   always_comb begin
      count_in       = count_ff;
      stopped_in     = stopped_ff;
      rsp.read_data  = '0;
      rsp.match_mask = '0;
      case (cmd.mode)
         MODE_TICK: begin
            if (!stopped_ff) begin
               count_in = next_count;
               for (int k = 0; k < SLOTS; k++) begin
                  rsp.match_mask[k] = (k < NUM_VPS) && (cmp_ff[k] == next_count);
               end
            end
         end
         MODE_WR_COUNT: count_in = cmd.data;
         MODE_RD_COUNT: rsp.read_data = count_ff;
         MODE_WR_CMP: ;
         MODE_RD_CMP: begin
            if (vp_ok) rsp.read_data = cmp_ff[cmd.vp];
         end
         MODE_START: stopped_in = 1'b0;
         MODE_STOP:  stopped_in = 1'b1;
         MODE_RD_STOP: rsp.read_data = DATA_W'(stopped_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         stopped_ff <= 1'b1;
      end else if (cmd.go) begin
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) cmp_ff[k] <= '0;
      end else if (cmp_we) begin
         cmp_ff[cmd.vp] <= cmd.data;
      end
   end

   `SCCT_ASSERT_NEXT(a_tick_advance, clock, reset,
      cmd.go && cmd.mode == MODE_TICK && !stopped_ff,
      count_ff == $past(count_ff) + DATA_W'(1), "running tick did not advance count")
   `SCCT_ASSERT_NEXT(a_idle_holds, clock, reset, !cmd.go,
      $stable(count_ff) && $stable(stopped_ff), "state changed without a beat")
   `SCCT_ASSERT_NEXT(a_stop_sets, clock, reset, cmd.go && cmd.mode == MODE_STOP,
      stopped_ff, "stop access did not set the stop flag")
   `SCCT_ASSERT_SAME(a_mask_tick_only, clock, reset,
      cmd.mode != MODE_TICK || stopped_ff, rsp.match_mask == '0,
      "match raised outside a running tick")

endmodule
`default_nettype wire

// File: src/shared_counter_compare_timer_core.sv
// Shared counter timer: one 32-bit up-counter, eight compare registers and a stop flag.
// Takes one beat per clock while req_stall is low, a tick or a register access, and
// returns exactly one result beat for each, in order. Between acceptance and result,
// the request is held in an input register, executed against the counter, compare
// bank and stop flag, and the result lands in an output register. Throughput is one
// beat per cycle unless rsp_stall holds the output; the counter state updates per beat.
// Results hold while rsp_stall is high, and req_stall rises only when both the input
// and output registers are full. The block leaves reset with the counter stopped.
`default_nettype none
module shared_counter_compare_timer_core
   import scct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [VP_W-1:0]   req_vp_index,
   input  wire logic [DATA_W-1:0] req_write_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [DATA_W-1:0] rsp_read_data,
   output      logic [SLOTS-1:0]  rsp_match_mask
);

   logic              in_valid_ff;
   mode_type          in_mode_ff;
   logic [VP_W-1:0]   in_vp_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;
   logic              advance;
   logic              req_take;
   cmd_type           cmd;
   rsp_type           exec_rsp;

   // Advance the execute stage when the output register is free or draining.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign cmd.go   = in_valid_ff && advance;
   assign cmd.mode = in_mode_ff;
   assign cmd.vp   = in_vp_ff;
   assign cmd.data = in_data_ff;

   scct_exec u_exec (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || advance) begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= mode_type'(req_mode);
         in_vp_ff   <= req_vp_index;
         in_data_ff <= req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) out_ff <= exec_rsp;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = out_ff.read_data;
   assign rsp_match_mask = out_ff.match_mask;

endmodule
`default_nettype wire
